>>> design/multi_level_block_allocator_defines.svh
// Assertion macros used by the checker file of the block allocator.
`ifndef MULTI_LEVEL_BLOCK_ALLOCATOR_DEFINES_SVH
`define MULTI_LEVEL_BLOCK_ALLOCATOR_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define MLBA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// When ante holds at one edge, cons must hold at the following edge.
`define MLBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/mlba_pkg.sv
package mlba_pkg;

    localparam int BASE_BLOCKS     = 16;
    localparam int TOP_BLOCK_BYTES = 1024;
    localparam int LEVELS          = 4;

    // Payload field widths.
    localparam int FUNC_W   = 2;
    localparam int SIZE_W   = 11;
    localparam int HANDLE_W = 8;
    localparam int LEVEL_W  = 2;
    localparam int STATUS_W = 2;
    localparam int BYTES_W  = 17;
    localparam int COUNT_W  = 8;

    localparam int S_TDATA_W = ((SIZE_W + HANDLE_W + LEVEL_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((HANDLE_W + LEVEL_W + BYTES_W + COUNT_W + 7) / 8) * 8;

    // Link storage geometry. The null link is one past the last handle.
    localparam int TOTAL_BLOCKS = BASE_BLOCKS * ((1 << LEVELS) - 1);
    localparam int LINK_W       = $clog2(TOTAL_BLOCKS + 1);
    localparam int ADDR_W       = (TOTAL_BLOCKS > 1) ? $clog2(TOTAL_BLOCKS) : 1;
    localparam int LVL_W        = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    localparam logic [LINK_W-1:0]  LINK_NULL = LINK_W'(TOTAL_BLOCKS);
    localparam logic [BYTES_W-1:0] BYTES_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Operation codes carried in the input tuser.
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // Result codes carried in the output tuser.
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_SIZE = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [LINK_W-1:0] wr_data;
        logic              clear;
    } t_link_req;

    // First handle of a pool.
    function automatic int level_base(input int lvl);
        return BASE_BLOCKS * ((1 << lvl) - 1);
    endfunction

    // Number of blocks in a pool.
    function automatic int level_count(input int lvl);
        return BASE_BLOCKS << lvl;
    endfunction

    // Link held by an entry after reset or clear: the next handle of the
    // same pool, or null for the last block of a pool.
    function automatic logic [LINK_W-1:0] reset_link(input logic [ADDR_W-1:0] addr);
        logic is_last;
        is_last = 1'b0;
        for (int l = 0; l < LEVELS; l++) begin
            if (int'(addr) + 1 == level_base(l + 1)) begin
                is_last = 1'b1;
            end
        end
        return is_last ? LINK_NULL : LINK_W'(int'(addr) + 1);
    endfunction

endpackage

>>> design/mlba_link_ram.sv
module mlba_link_ram (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mlba_pkg::t_link_req       i_req,
    output logic [mlba_pkg::LINK_W-1:0] o_rd_link
);
    import mlba_pkg::*;

    logic [LINK_W-1:0]       r_mem [TOTAL_BLOCKS];
    logic [TOTAL_BLOCKS-1:0] r_valid;
    logic [LINK_W-1:0]       r_rd_data;
    logic                    r_rd_valid;
    logic [ADDR_W-1:0]       r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    // An entry that was never written since reset or clear holds its chain link.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clear) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_valid <= r_valid[i_req.rd_addr];
            r_rd_addr  <= i_req.rd_addr;
        end
    end

    assign o_rd_link = r_rd_valid ? r_rd_data : reset_link(r_rd_addr);

endmodule

>>> design/multi_level_block_allocator.sv
// An accepted item is carried out in the execute state, which registers its result in the
// output register; it waits there while an earlier result still sits in that register.
// A new item is taken only once the last one is done: a pop needs the read of the link
// memory, issued in the idle state, before the pool head can move.
// Reset: synchronous, active low; pool heads go to each pool's first block, counters
// clear and all link valid bits clear, so the block is ready right away.
module multi_level_block_allocator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // request_size, free_handle, free_level (zero padded to bytes)
    input  logic [mlba_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // func
    input  logic [mlba_pkg::FUNC_W-1:0]         s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // block_handle, block_level, used_bytes, live_allocations (zero padded to bytes)
    output logic [mlba_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // status
    output logic [mlba_pkg::STATUS_W-1:0]       m_axis_tuser
);
    import mlba_pkg::*;

    // The free lists live in one link memory: entry h holds the handle that
    // follows h in its pool's list. Pool heads, the byte count and the live
    // allocation count sit in flip-flops. A beat is taken in the idle state,
    // which for an allocate also issues the read of the head's link; the execute state then
    // pops, pushes or clears and loads the output register. A write only
    // happens in the execute state and a read only in the idle state, so the
    // same entry is never read and written in one cycle.

    // Input fields.
    logic [FUNC_W-1:0]   w_func;
    logic [SIZE_W-1:0]   w_size;
    logic [HANDLE_W-1:0] w_fhandle;
    logic [LEVEL_W-1:0]  w_flevel;

    assign w_func    = s_axis_tuser;
    assign w_size    = s_axis_tdata[SIZE_W-1:0];
    assign w_fhandle = s_axis_tdata[SIZE_W +: HANDLE_W];
    assign w_flevel  = s_axis_tdata[SIZE_W + HANDLE_W +: LEVEL_W];

    t_state r_state, n_state;

    logic [FUNC_W-1:0]  r_func,     n_func;
    logic [LVL_W-1:0]   r_lvl,      n_lvl;
    logic [LEVEL_W-1:0] r_out_lvl,  n_out_lvl;
    logic               r_bad_size, n_bad_size;
    logic               r_free_ok,  n_free_ok;
    logic [ADDR_W-1:0]  r_handle,   n_handle;

    logic [LINK_W-1:0]  r_head [LEVELS];
    logic [LINK_W-1:0]  n_head [LEVELS];
    logic [BYTES_W-1:0] r_bytes, n_bytes;
    logic [COUNT_W-1:0] r_count, n_count;

    logic                 r_m_valid, n_m_valid;
    logic [M_TDATA_W-1:0] r_m_tdata, n_m_tdata;
    logic [STATUS_W-1:0]  r_m_tuser, n_m_tuser;

    t_link_req         w_req;
    logic [LINK_W-1:0] w_rd_link;

    // Decode of the incoming beat.
    logic             w_size_bad;
    logic [LVL_W-1:0] w_alloc_lvl;
    logic [LVL_W-1:0] w_free_lvl;
    logic             w_free_ok;

    always_comb begin
        w_size_bad = (w_size == '0) || (int'(w_size) > TOP_BLOCK_BYTES);
        // Deepest pool whose block size still covers the request.
        w_alloc_lvl = '0;
        for (int i = 1; i < LEVELS; i++) begin
            if ((TOP_BLOCK_BYTES >> i) >= int'(w_size)) begin
                w_alloc_lvl = LVL_W'(i);
            end
        end
        w_free_lvl = LVL_W'(w_flevel);
        w_free_ok  = (int'(w_flevel) < LEVELS)
                  && (int'(w_fhandle) >= level_base(int'(w_flevel)))
                  && (int'(w_fhandle) < level_base(int'(w_flevel))
                                      + level_count(int'(w_flevel)));
    end

    // Values used by the execute state.
    logic [LINK_W-1:0]  w_head;
    logic [BYTES_W-1:0] w_blk;
    logic [BYTES_W:0]   w_sum;

    assign w_head = r_head[r_lvl];
    assign w_blk  = BYTES_W'(TOP_BLOCK_BYTES) >> r_lvl;
    assign w_sum  = {1'b0, r_bytes} + {1'b0, w_blk};

    logic [STATUS_W-1:0] w_status;
    logic [HANDLE_W-1:0] w_out_handle;
    logic [LEVEL_W-1:0]  w_res_lvl;

    always_comb begin
        n_state    = r_state;
        n_func     = r_func;
        n_lvl      = r_lvl;
        n_out_lvl  = r_out_lvl;
        n_bad_size = r_bad_size;
        n_free_ok  = r_free_ok;
        n_handle   = r_handle;
        n_head     = r_head;
        n_bytes    = r_bytes;
        n_count    = r_count;
        n_m_valid  = r_m_valid && !m_axis_tready;
        n_m_tdata  = r_m_tdata;
        n_m_tuser  = r_m_tuser;
        w_req      = '0;
        w_status     = STATUS_OK;
        w_out_handle = '0;
        w_res_lvl    = '0;
        s_axis_tready = (r_state == ST_IDLE);

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_func     = w_func;
                    n_bad_size = w_size_bad;
                    n_free_ok  = w_free_ok;
                    n_handle   = ADDR_W'(w_fhandle);
                    if (w_func == FUNC_ALLOC) begin
                        n_lvl     = w_alloc_lvl;
                        n_out_lvl = LEVEL_W'(w_alloc_lvl);
                        // Fetch the successor of the head the pop will take.
                        if (!w_size_bad && (r_head[w_alloc_lvl] != LINK_NULL)) begin
                            w_req.rd_en   = 1'b1;
                            w_req.rd_addr = ADDR_W'(r_head[w_alloc_lvl]);
                        end
                    end else begin
                        n_lvl     = w_free_lvl;
                        n_out_lvl = w_flevel;
                    end
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // Wait here while an earlier result still sits unread.
                if (!r_m_valid || m_axis_tready) begin
                    case (r_func)
                        FUNC_ALLOC: begin
                            if (r_bad_size) begin
                                w_status = STATUS_BAD_SIZE;
                            end else if (w_head == LINK_NULL) begin
                                w_status  = STATUS_EMPTY;
                                w_res_lvl = r_out_lvl;
                            end else begin
                                w_res_lvl     = r_out_lvl;
                                w_out_handle  = HANDLE_W'(w_head);
                                n_head[r_lvl] = w_rd_link;
                                n_bytes = w_sum[BYTES_W] ? BYTES_MAX : w_sum[BYTES_W-1:0];
                                if (r_count < COUNT_MAX) begin
                                    n_count = r_count + 1'b1;
                                end
                            end
                        end
                        FUNC_FREE: begin
                            w_res_lvl = r_out_lvl;
                            if (r_free_ok) begin
                                // Push: the freed block points at the old head.
                                w_req.wr_en   = 1'b1;
                                w_req.wr_addr = r_handle;
                                w_req.wr_data = w_head;
                                n_head[r_lvl] = LINK_W'(r_handle);
                                n_bytes = (r_bytes > w_blk) ? r_bytes - w_blk : '0;
                                if (r_count != '0) begin
                                    n_count = r_count - 1'b1;
                                end
                            end
                        end
                        FUNC_CLEAR: begin
                            w_req.clear = 1'b1;
                            for (int l = 0; l < LEVELS; l++) begin
                                n_head[l] = LINK_W'(level_base(l));
                            end
                            n_bytes = '0;
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                    n_m_valid = 1'b1;
                    n_m_tuser = w_status;
                    n_m_tdata = M_TDATA_W'({n_count, n_bytes, w_res_lvl, w_out_handle});
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LEVELS; l++) begin
                r_head[l] <= LINK_W'(level_base(l));
            end
            r_bytes   <= '0;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_bytes   <= n_bytes;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
        end
    end

    // Captured item and result payload need no reset.
    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_lvl      <= n_lvl;
        r_out_lvl  <= n_out_lvl;
        r_bad_size <= n_bad_size;
        r_free_ok  <= n_free_ok;
        r_handle   <= n_handle;
        r_m_tdata  <= n_m_tdata;
        r_m_tuser  <= n_m_tuser;
    end

    mlba_link_ram u_link_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .o_rd_link (w_rd_link)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

endmodule

>>> design/mlba_checker.sv
`include "multi_level_block_allocator_defines.svh"

module mlba_port_checks (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [mlba_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic [mlba_pkg::FUNC_W-1:0]    s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [mlba_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [mlba_pkg::STATUS_W-1:0]  m_axis_tuser
);
    import mlba_pkg::*;

    // A stalled result beat stays put.
    `MLBA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed while stalled")

    // Each item passes through the execute state, so no beat is taken right after another.
    `MLBA_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken in back to back cycles")

    // A failed allocate grants no handle.
    `MLBA_ASSERT(a_fail_no_handle, i_clk, i_rst_n, (m_axis_tvalid && (m_axis_tuser != STATUS_OK)) |-> (m_axis_tdata[HANDLE_W-1:0] == '0), "handle granted on failed request")

    // A rejected size reports level zero.
    `MLBA_ASSERT(a_bad_size_level, i_clk, i_rst_n, (m_axis_tvalid && (m_axis_tuser == STATUS_BAD_SIZE)) |-> (m_axis_tdata[HANDLE_W +: LEVEL_W] == '0), "level set on invalid size")

endmodule

bind multi_level_block_allocator mlba_port_checks u_mlba_port_checks (.*);
